// ===== rtl/bounded_priority_queue_evict_lowest_top_defines.svh =====
// Assertion macros for the bounded priority queue.
// No dependencies; clocked on aclk, disabled while aresetn is low.
`ifndef BOUNDED_PRIORITY_QUEUE_EVICT_LOWEST_TOP_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_EVICT_LOWEST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BPQEL_ASSERT(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");
`define BPQEL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPQEL_ASSERT(label, expr)
`define BPQEL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/bpqel_pkg.sv =====
// Shared types and constants for the bounded priority queue.
// No dependencies.
package bpqel_pkg;

    localparam int DEPTH      = 16;
    localparam int TAG_BITS   = 16;
    localparam int LEVEL_BITS = 8;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMIT_W    = 5;
    localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int OCC_W      = 5;
    localparam int DROP_W     = 32;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_SERVE   = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_EVICTED  = 3'd1,
        ST_REJECTED = 3'd2,
        ST_SENT     = 3'd3,
        ST_BUSY     = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_UP
    } cell_op_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [LEVEL_BITS-1:0] level;
    } entry_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [15:0]           packet_tag;
        logic [7:0]            priority_level;
        logic                  downstream_ready;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [15:0]           out_tag;
        logic [7:0]            out_level;
        logic [OCC_W-1:0]      occupancy;
        logic [DROP_W-1:0]     drops_seen;
    } out_item_t;

endpackage

// ===== rtl/bpqel_cell.sv =====
// One slot of the sorted queue: holds an entry, trades with its neighbors.
// Depends on bpqel_pkg.
module bpqel_cell (
    input  logic              aclk,
    input  bpqel_pkg::cell_op_t op,
    input  logic              occ,
    input  bpqel_pkg::entry_t new_entry,
    input  bpqel_pkg::entry_t prev_entry,
    input  logic              prev_ge,
    input  bpqel_pkg::entry_t next_entry,
    output bpqel_pkg::entry_t entry_q,
    output logic              ge
);
    import bpqel_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Occupied and at or above the incoming level: new item goes behind us.
    assign ge = occ && (entry_reg.level >= new_entry.level);

    always_comb begin
        entry_next = entry_reg;
        unique case (op)
            CELL_HOLD:     entry_next = entry_reg;
            CELL_SHIFT_UP: entry_next = next_entry;
            CELL_INSERT: begin
                priority if (ge)      entry_next = entry_reg;
                else if (prev_ge)     entry_next = new_entry;
                else                  entry_next = prev_entry;
            end
            default:       entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

// ===== rtl/bounded_priority_queue_evict_lowest_top.sv =====
// Top level of the bounded priority queue with lowest-level eviction.
// Depends on bpqel_pkg, bpqel_cell and the assertion macro header.
//
// Usage:
//  - s_* channel: one item per handshake, an enqueue (tag + level) or a serve
//    attempt carrying the downstream ready flag.
//  - m_* channel: exactly one result item per input item, in order: status,
//    reported tag/level, occupancy after the step and the running drop count.
//  - cfg_* channel: writes queue_limit (0 acts as 1, above DEPTH acts as DEPTH).
//    Always ready; write only while the queue has no result in flight.
// Timing: an item is processed in the cycle it is accepted and its result is
//  on m_data the next cycle. One item per cycle sustained while m_ready stays
//  high: the row of DEPTH cells does a sorted insert, evict or head removal in
//  a single step, each cell comparing only its own level with the incoming one.
// Stall: the result register holds while m_ready is low; s_ready drops then,
//  and rises in the same cycle the result is taken.
// Reset: entry count, drop count and result valid clear, queue_limit goes to 1.
//  The cell contents are not cleared; only cells below the count are read.
`include "bounded_priority_queue_evict_lowest_top_defines.svh"

module bounded_priority_queue_evict_lowest_top (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bpqel_pkg::in_item_t    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bpqel_pkg::out_item_t   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [bpqel_pkg::LIMIT_W-1:0] cfg_data
);
    import bpqel_pkg::*;

    // control state
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DROP_W-1:0]  drop_total_reg, drop_total_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg, m_data_next;

    // cell row
    entry_t             cell_q [DEPTH];
    logic               cell_ge [DEPTH];
    logic               cell_occ [DEPTH];
    cell_op_t           cell_op;
    entry_t             new_entry;

    logic               fire;
    logic [CMP_W-1:0]   eff_limit;
    logic               full;
    logic               evict;
    logic               reject;
    logic [CNT_W-1:0]   live_count;   // count the insert sees, after eviction
    logic [IDX_W-1:0]   tail_idx;
    entry_t             tail_entry;
    entry_t             head_entry;

    assign s_ready   = !m_valid_reg || m_ready;
    assign fire      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // clamp the limit into 1..DEPTH
    always_comb begin
        priority if (limit_reg == '0)
            eff_limit = CMP_W'(1);
        else if (CMP_W'(limit_reg) > CMP_W'(DEPTH))
            eff_limit = CMP_W'(DEPTH);
        else
            eff_limit = CMP_W'(limit_reg);
    end

    assign full       = CMP_W'(count_reg) >= eff_limit;
    assign tail_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign tail_entry = cell_q[tail_idx];
    assign head_entry = cell_q[0];
    assign new_entry  = '{tag: TAG_BITS'(s_data.packet_tag),
                          level: LEVEL_BITS'(s_data.priority_level)};

    // full queue: the tail is the lowest and newest entry
    assign reject = (s_data.opcode == OP_ENQUEUE) && full
                    && (new_entry.level <= tail_entry.level);
    assign evict  = (s_data.opcode == OP_ENQUEUE) && full && !reject;
    assign live_count = evict ? count_reg - CNT_W'(1) : count_reg;

    always_comb begin
        cell_op = CELL_HOLD;
        if (fire) begin
            unique case (s_data.opcode)
                OP_ENQUEUE: cell_op = reject ? CELL_HOLD : CELL_INSERT;
                OP_SERVE:   cell_op = (count_reg != '0 && s_data.downstream_ready)
                                      ? CELL_SHIFT_UP : CELL_HOLD;
                default:    cell_op = CELL_HOLD;
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_occ[i] = CNT_W'(i) < live_count;
        bpqel_cell u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .occ        (cell_occ[i]),
            .new_entry  (new_entry),
            .prev_entry ((i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i - 1]),
            .prev_ge    ((i == 0) ? 1'b1 : cell_ge[(i == 0) ? 0 : i - 1]),
            .next_entry ((i == DEPTH - 1) ? cell_q[i] : cell_q[(i == DEPTH - 1) ? i : i + 1]),
            .entry_q    (cell_q[i]),
            .ge         (cell_ge[i])
        );
    end

    // result and counters for the accepted item
    always_comb begin
        count_next      = count_reg;
        drop_total_next = drop_total_reg;
        m_data_next     = '0;
        unique case (s_data.opcode)
            OP_ENQUEUE: begin
                if (full) drop_total_next = drop_total_reg + DROP_W'(1);
                priority if (reject) begin
                    m_data_next.status    = ST_REJECTED;
                    m_data_next.out_tag   = 16'(new_entry.tag);
                    m_data_next.out_level = 8'(new_entry.level);
                end else if (evict) begin
                    m_data_next.status    = ST_EVICTED;
                    m_data_next.out_tag   = 16'(tail_entry.tag);
                    m_data_next.out_level = 8'(tail_entry.level);
                end else begin
                    m_data_next.status    = ST_ACCEPTED;
                    count_next            = count_reg + CNT_W'(1);
                end
            end
            OP_SERVE: begin
                priority if (count_reg == '0) begin
                    m_data_next.status    = ST_EMPTY;
                end else if (s_data.downstream_ready) begin
                    m_data_next.status    = ST_SENT;
                    m_data_next.out_tag   = 16'(head_entry.tag);
                    m_data_next.out_level = 8'(head_entry.level);
                    count_next            = count_reg - CNT_W'(1);
                end else begin
                    m_data_next.status    = ST_BUSY;
                end
            end
            default: m_data_next.status = ST_EMPTY;
        endcase
        m_data_next.occupancy  = OCC_W'(count_next);
        m_data_next.drops_seen = drop_total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            drop_total_reg <= '0;
            limit_reg      <= LIMIT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) limit_reg <= cfg_data;
            if (fire) begin
                count_reg      <= count_next;
                drop_total_reg <= drop_total_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `BPQEL_ASSERT(a_count_bound, CMP_W'(count_reg) <= CMP_W'(DEPTH))
    `BPQEL_ASSERT_NEXT(a_drop_hold, !fire, $stable(drop_total_reg))
    `BPQEL_ASSERT_NEXT(a_serve_pops,
        fire && s_data.opcode == OP_SERVE && s_data.downstream_ready && count_reg != '0,
        count_reg == $past(count_reg) - CNT_W'(1))
    for (genvar j = 1; j < DEPTH; j++) begin : g_sorted
        `BPQEL_ASSERT(a_sorted, (CNT_W'(j) < count_reg) |-> (cell_q[j-1].level >= cell_q[j].level))
    end

endmodule
